// ----- rtl/bpb_pkg.sv -----
`default_nettype none

package bpb_pkg;

  // Field widths of the stream words
  localparam int unsigned BUCKET_W   = 12;
  localparam int unsigned RECORD_W   = 20;
  localparam int unsigned POSITION_W = 8;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned OUT_REC_W  = RECORD_W + 1;
  localparam int unsigned OUT_POS_W  = POSITION_W + 1;
  localparam int unsigned COUNT_W    = 24;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (OUT_REC_W + OUT_POS_W + BUCKET_W + COUNT_W);

  // Storage geometry
  localparam int unsigned NUM_BUCKETS      = 1 << BUCKET_W;
  localparam int unsigned PAIRS_PER_BUFFER = 16;
  localparam int unsigned FILL_W           = $clog2(PAIRS_PER_BUFFER + 1);
  localparam int unsigned PAIR_W           = RECORD_W + POSITION_W;
  localparam int unsigned STORE_DEPTH      = NUM_BUCKETS * PAIRS_PER_BUFFER;
  localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);

  localparam logic [CFG_W-1:0]   CFG_RESET   = CFG_W'(NUM_BUCKETS);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(PAIRS_PER_BUFFER);
  localparam logic [BUCKET_W-1:0] BUCKET_LAST = BUCKET_W'(NUM_BUCKETS - 1);

  // Operation codes carried in tuser
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } bpb_state_t;

endpackage

`default_nettype wire

// ----- rtl/bpb_ram.sv -----
`default_nettype none

module bpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bucketed_posting_buffer.sv -----
`default_nettype none
// Append: accept, then fill-count lookup/writeback; no result unless the buffer fills.
// Emit: one result per cycle while the output is not stalled, once the pair-store read returns;
//   input held off until the last result of the buffer has entered the output register.
// Throughput is set by the fill-count read-modify-write and the pair-store read.
// Reset: synchronous; a clearing pass over every bucket zeroes the fill counts, during which
//   no input word is taken (configuration writes are always taken).
module bucketed_posting_buffer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: buckets_in_use
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [bpb_pkg::CFG_W-1:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [11:0] bucket, [31:12] record_id, [39:32] position
  input  wire logic [bpb_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] operation
  input  wire logic        s_tuser,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [20:0] out_record, [29:21] out_position, [41:30] out_bucket,
  // [65:42] blocks_emitted, [71:66] zero
  output logic [bpb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic             m_tlast
);

  import bpb_pkg::*;

  // Unpack the input word
  logic [BUCKET_W-1:0]   s_bucket;
  logic [RECORD_W-1:0]   s_record;
  logic [POSITION_W-1:0] s_position;

  assign s_bucket   = s_tdata[BUCKET_W-1:0];
  assign s_record   = s_tdata[BUCKET_W+RECORD_W-1:BUCKET_W];
  assign s_position = s_tdata[BUCKET_W+RECORD_W+POSITION_W-1:BUCKET_W+RECORD_W];

  bpb_state_t state, state_next;

  logic [CFG_W-1:0]      buckets_in_use;
  logic [COUNT_W-1:0]    block_counter;
  logic [BUCKET_W-1:0]   clr_addr;

  // Latched item
  logic                  it_op;
  logic [BUCKET_W-1:0]   it_bucket;
  logic [RECORD_W-1:0]   it_record;
  logic [POSITION_W-1:0] it_position;

  // Emission sequencer
  logic [FILL_W-1:0]     emit_slot;
  logic [FILL_W-1:0]     emit_fill;
  logic [FILL_W-1:0]     pend_slot;
  logic                  pend;

  // Output register
  logic [OUT_REC_W-1:0]  o_record;
  logic [OUT_POS_W-1:0]  o_position;
  logic [BUCKET_W-1:0]   o_bucket;
  logic                  o_last;
  logic [COUNT_W-1:0]    o_blocks;

  // Memory ports
  logic                  fill_we;
  logic [BUCKET_W-1:0]   fill_waddr;
  logic [FILL_W-1:0]     fill_wdata;
  logic                  fill_re;
  logic [FILL_W-1:0]     fill_rdata;
  logic                  pair_we;
  logic [STORE_AW-1:0]   pair_waddr;
  logic [PAIR_W-1:0]     pair_wdata;
  logic [STORE_AW-1:0]   pair_raddr;
  logic [PAIR_W-1:0]     pair_rdata;

  logic                  accept;
  logic                  active;
  logic [FILL_W-1:0]     fill_base;
  logic [FILL_W-1:0]     fill_inc;
  logic                  is_full;
  logic                  start_emit;
  logic                  load;
  logic                  rd_issue;
  logic                  emit_done;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign active    = ({1'b0, s_bucket} < buckets_in_use);

  // Fill count as looked up; a full count would wrap to the first slot
  assign fill_base  = (fill_rdata >= FILL_FULL) ? '0 : fill_rdata;
  assign fill_inc   = fill_base + FILL_W'(1);
  assign is_full    = (fill_inc == FILL_FULL);
  assign start_emit = (state == ST_LOOKUP) && ((it_op == OP_DRAIN) || is_full);

  // Move pending read data into the output register when it is free
  assign load      = pend && (!m_tvalid || m_tready);
  assign rd_issue  = (state == ST_EMIT) && (emit_slot != FILL_FULL) && (!pend || load);
  assign emit_done = (emit_slot == FILL_FULL) && (!pend || load);

  assign fill_re    = accept && active;
  assign pair_we    = (state == ST_LOOKUP) && (it_op == OP_APPEND);
  assign pair_waddr = STORE_AW'(it_bucket) * STORE_AW'(PAIRS_PER_BUFFER) + STORE_AW'(fill_base);
  assign pair_wdata = {it_position, it_record};
  assign pair_raddr = STORE_AW'(it_bucket) * STORE_AW'(PAIRS_PER_BUFFER) + STORE_AW'(emit_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fill_we    = 1'b0;
    fill_waddr = it_bucket;
    fill_wdata = '0;
    case (state)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_addr;
        if (clr_addr == BUCKET_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (fill_re) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        fill_we = 1'b1;
        if ((it_op == OP_APPEND) && !is_full) begin
          fill_wdata = fill_inc;
        end
        state_next = start_emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_in_use <= CFG_RESET;
      block_counter  <= '0;
      clr_addr       <= '0;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
      emit_slot      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buckets_in_use <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BUCKET_W'(1);
      end
      // count the buffer as its emission starts; saturate
      if (start_emit && (block_counter != COUNT_MAX)) begin
        block_counter <= block_counter + COUNT_W'(1);
      end
      if (start_emit) begin
        emit_slot <= '0;
      end else if (rd_issue) begin
        emit_slot <= emit_slot + FILL_W'(1);
      end
      if (rd_issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op       <= s_tuser;
      it_bucket   <= s_bucket;
      it_record   <= s_record;
      it_position <= s_position;
    end
    if (start_emit) begin
      emit_fill <= (it_op == OP_DRAIN) ? fill_rdata : FILL_FULL;
    end
    if (rd_issue) begin
      pend_slot <= emit_slot;
    end
    if (load) begin
      // slots beyond the fill go out as empty pairs
      if (pend_slot < emit_fill) begin
        o_record   <= {1'b0, pair_rdata[RECORD_W-1:0]};
        o_position <= {1'b0, pair_rdata[PAIR_W-1:RECORD_W]};
      end else begin
        o_record   <= '1;
        o_position <= '1;
      end
      o_bucket <= it_bucket;
      o_last   <= (pend_slot == FILL_FULL - FILL_W'(1));
      o_blocks <= block_counter;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, o_blocks, o_bucket, o_position, o_record};
  assign m_tlast = o_last;

  bpb_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (s_bucket),
    .rdata (fill_rdata)
  );

  bpb_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STORE_DEPTH)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (rd_issue),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

`ifndef SYNTHESIS
  a_no_output_in_clear : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !m_tvalid)
    else $error("output word during clearing pass");

  a_pend_only_in_emit : assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_EMIT))
    else $error("pair read pending outside emission");

  a_slot_in_range : assert property (@(posedge clk) disable iff (rst)
    (emit_slot <= FILL_FULL))
    else $error("emission slot out of range");

  a_fill_written_below_full : assert property (@(posedge clk) disable iff (rst)
    fill_we |-> (fill_wdata < FILL_FULL))
    else $error("fill count written at or above buffer size");

  a_emit_follows_lookup : assert property (@(posedge clk) disable iff (rst)
    start_emit |=> (state == ST_EMIT) && (emit_slot == '0))
    else $error("emission did not start from the first slot");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import bpb_pkg::*;

  // Allow an emission plus margin after the last expected posting, since a
  // pending append may still be in flight.
  localparam int unsigned SETTLE_CYCLES   = 24;
  // Cycles with no word moved on any channel before the run is abandoned.
  // This covers the clearing pass after reset.
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned ITEMS_PER_PHASE = 62;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  // One request to the buffer: an append of an occurrence, or a drain of a bucket
  typedef struct packed {
    logic                  op;
    logic [BUCKET_W-1:0]   bucket;
    logic [RECORD_W-1:0]   record_id;
    logic [POSITION_W-1:0] position;
  } request_t;

  // One emitted posting (one slot of a bucket's buffer)
  typedef struct packed {
    logic [OUT_REC_W-1:0] rec;
    logic [OUT_POS_W-1:0] pos;
    logic [BUCKET_W-1:0]  bucket;
    logic                 last;
    logic [COUNT_W-1:0]   blocks;
  } posting_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // [11:0] bucket, [31:12] record_id, [39:32] position
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  // [0] operation
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [20:0] out_record, [29:21] out_position, [41:30] out_bucket,
  // [65:42] blocks_emitted, [71:66] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Bucket limits visited in turn, the extremes among them. Zero leaves every
  // bucket inactive; 8191 sets every bit of the register.
  int unsigned phase_limit [NUM_PHASES] = '{1, 4096, 6, 8191, 0, 4095, 2, 300};

  // Own copy of the index state
  logic [RECORD_W-1:0]   stored_record   [STORE_DEPTH];
  logic [POSITION_W-1:0] stored_position [STORE_DEPTH];
  logic [FILL_W-1:0]     bucket_fill     [NUM_BUCKETS];
  logic [COUNT_W-1:0]    blocks_out;
  logic [CFG_W-1:0]      active_buckets;

  request_t    request_q[$];
  posting_t    posting_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_stall   = 0;
  int unsigned recv_calm    = 0;

  bucketed_posting_buffer i_dut (
    .clk,
    .rst,
    .cfg_valid,
    .cfg_ready,
    .cfg_data,
    .s_tvalid,
    .s_tready,
    .s_tdata,
    .s_tuser,
    .m_tvalid,
    .m_tready,
    .m_tdata,
    .m_tlast
  );

  always #5 clk = ~clk;

  // Emit the whole buffer of one bucket: stored pairs first, then empty slots
  // as all-ones pairs. Count the block, saturating, and empty the bucket.
  function automatic void flush_bucket(input logic [BUCKET_W-1:0] b);
    posting_t    p;
    int unsigned idx;
    int unsigned s;
    if (blocks_out != COUNT_MAX) begin
      blocks_out = blocks_out + 1'b1;
    end
    for (s = 0; s < PAIRS_PER_BUFFER; s++) begin
      idx = b * PAIRS_PER_BUFFER + s;
      if (s < bucket_fill[b]) begin
        p.rec = {1'b0, stored_record[idx]};
        p.pos = {1'b0, stored_position[idx]};
      end else begin
        p.rec = '1;
        p.pos = '1;
      end
      p.bucket = b;
      p.last   = (s == PAIRS_PER_BUFFER - 1);
      p.blocks = blocks_out;
      posting_q.push_back(p);
    end
    bucket_fill[b] = '0;
  endfunction

  // Apply one accepted request to the index and queue the postings it causes
  function automatic void index_request(input request_t r);
    logic [FILL_W-1:0] f;
    int unsigned       idx;
    // inactive bucket: drop the word without effect
    if ({1'b0, r.bucket} >= active_buckets) begin
      return;
    end
    if (r.op == OP_DRAIN) begin
      flush_bucket(r.bucket);
      return;
    end
    f = bucket_fill[r.bucket];
    if (f >= FILL_FULL) begin
      f = '0;
    end
    idx = r.bucket * PAIRS_PER_BUFFER + f;
    stored_record[idx]   = r.record_id;
    stored_position[idx] = r.position;
    bucket_fill[r.bucket] = f + 1'b1;
    // the append that fills the buffer emits it at once
    if (bucket_fill[r.bucket] == FILL_FULL) begin
      flush_bucket(r.bucket);
    end
  endfunction

  function automatic void push_request(input logic op, input logic [BUCKET_W-1:0] b,
                                       input logic [RECORD_W-1:0] rec,
                                       input logic [POSITION_W-1:0] pos);
    request_t r;
    r.op        = op;
    r.bucket    = b;
    r.record_id = rec;
    r.position  = pos;
    request_q.push_back(r);
  endfunction

  // Idle length for either side: mostly none or short, a few long, and now
  // and then a calm stretch with no idling at all.
  function automatic int unsigned pick_pause(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // Driver: present the head of the request queue, hold it until taken, then
  // predict its postings and advance after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        index_request(request_q.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {request_q[0].position, request_q[0].record_id, request_q[0].bucket};
          s_tuser  <= request_q[0].op;
          send_gap = pick_pause(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each posting word taken against the oldest expectation,
  // and stall the output side at random.
  always @(posedge clk) begin : receive
    posting_t got;
    posting_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rec    = m_tdata[20:0];
        got.pos    = m_tdata[29:21];
        got.bucket = m_tdata[41:30];
        got.blocks = m_tdata[65:42];
        got.last   = m_tlast;
        if (posting_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("unexpected posting word: rec %0d pos %0d bucket %0d last %0b blocks %0d",
                     $signed(got.rec), $signed(got.pos), got.bucket, got.last, got.blocks);
          end
        end else begin
          want = posting_q.pop_front();
          if (got != want || m_tdata[71:66] != '0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("posting mismatch: expected rec %0d pos %0d bucket %0d last %0b blocks %0d",
                       $signed(want.rec), $signed(want.pos), want.bucket, want.last,
                       want.blocks);
              $display("  got rec %0d pos %0d bucket %0d last %0b blocks %0d pad %0h",
                       $signed(got.rec), $signed(got.pos), got.bucket, got.last, got.blocks,
                       m_tdata[71:66]);
            end
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_stall = pick_pause(recv_calm);
      end
    end
  end

  // Watchdog: give up when no word has moved on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[bucketed_posting_buffer] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned         i;
    int unsigned         p;
    int unsigned         limit;
    int unsigned         span;
    int unsigned         tries;
    int unsigned         hot_n;
    int unsigned         r;
    logic [BUCKET_W-1:0] hot [3];
    logic [BUCKET_W-1:0] b;
    logic                op;

    for (i = 0; i < NUM_BUCKETS; i++) begin
      bucket_fill[i] = '0;
    end
    blocks_out     = '0;
    active_buckets = CFG_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset limit. Extremes of record and position,
    // the top and bottom buckets, alternating bit patterns.
    push_request(OP_APPEND, 12'd0, 20'hFFFFF, 8'hFF);
    push_request(OP_APPEND, 12'd0, 20'h00000, 8'h00);
    push_request(OP_APPEND, BUCKET_LAST, 20'hAAAAA, 8'h55);
    push_request(OP_APPEND, BUCKET_LAST, 20'h55555, 8'hAA);
    // drain a part-filled bucket: two pairs then empty slots
    push_request(OP_DRAIN, BUCKET_LAST, 20'h12345, 8'h67);
    // drain a bucket that was never written: all empty slots
    push_request(OP_DRAIN, 12'd100, 20'h0, 8'h0);
    // fill one buffer so that the last append emits it
    for (i = 0; i < PAIRS_PER_BUFFER; i++) begin
      push_request(OP_APPEND, 12'd9, RECORD_W'($urandom), POSITION_W'($urandom));
    end
    // drain the bucket just emptied, then the first one
    push_request(OP_DRAIN, 12'd9, 20'h0, 8'h0);
    push_request(OP_DRAIN, 12'd0, 20'h0, 8'h0);

    for (p = 0; p < NUM_PHASES; p++) begin
      // write the limit only once the buffer has gone quiet
      while (request_q.size() != 0 || posting_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= CFG_W'(phase_limit[p]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      active_buckets = CFG_W'(phase_limit[p]);
      cfg_valid <= 1'b0;

      limit = phase_limit[p];
      span  = (limit > NUM_BUCKETS) ? NUM_BUCKETS : limit;
      if (span == 0) begin
        // nothing is active: every word is dropped
        for (i = 0; i < 12; i++) begin
          push_request(1'($urandom_range(0, 1)), BUCKET_W'($urandom), RECORD_W'($urandom),
                       POSITION_W'($urandom));
        end
      end else begin
        // Concentrate on a few hot buckets so buffers actually fill; mix in
        // drains, stray buckets across the whole range and the boundary.
        hot_n = $urandom_range(1, 3);
        for (i = 0; i < 3; i++) begin
          hot[i] = BUCKET_W'($urandom_range(0, span - 1));
        end
        tries  = 0;
        while (tries < ITEMS_PER_PHASE) begin
          r  = $urandom_range(0, 99);
          b  = hot[$urandom_range(0, hot_n - 1)];
          op = OP_APPEND;
          if (r >= 68 && r < 76) begin
            op = OP_DRAIN;
          end else if (r >= 76 && r < 86) begin
            b = BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1));
          end else if (r >= 86 && r < 92) begin
            op = OP_DRAIN;
            b  = BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1));
          end else if (r >= 92) begin
            // just below or just at the limit
            b = BUCKET_W'(($urandom_range(0, 1) != 0 || span == NUM_BUCKETS) ? span - 1 : span);
          end
          push_request(op, b, RECORD_W'($urandom), POSITION_W'($urandom_range(0, 255)));
          tries++;
        end
      end
    end

    while (request_q.size() != 0 || posting_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[bucketed_posting_buffer] OK");
    end else begin
      $display("[bucketed_posting_buffer] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bpb_pkg.sv
rtl/bpb_ram.sv
rtl/bucketed_posting_buffer.sv
tb/sv/tb.sv
